// ----- sv/tlb_pkg.sv -----
`timescale 1ns / 1ps

package tlb_pkg;

	localparam int TLB_ENTRIES_DEF = 16;
	localparam int PAGE_BITS       = 20;
	localparam int ACTIVE_W        = 5;
	localparam int INDEX_OUT_W     = 4;
	localparam int COUNT_W         = 32;

	localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = ACTIVE_W'(16);

	typedef struct packed {
		logic [PAGE_BITS-1:0] virtual_page;
		logic                 is_write;
		logic [PAGE_BITS-1:0] walk_frame;
	} req_t;

	typedef struct packed {
		logic [PAGE_BITS-1:0]   frame;
		logic                   hit;
		logic [INDEX_OUT_W-1:0] filled_index;
		logic [COUNT_W-1:0]     hit_total;
	} rsp_t;

	// Commands from the sequencer to the datapath.
	typedef struct packed {
		logic load_req;
		logic lookup;
		logic load_out;
	} ctrl_cmd_t;

endpackage

// ----- sv/tlb_ram.sv -----
`timescale 1ns / 1ps

module tlb_ram #(
	parameter int WIDTH = 20,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- sv/tlb_ctrl.sv -----
`timescale 1ns / 1ps

module tlb_ctrl
	import tlb_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	output logic       out_valid,
	input  logic       out_ready,
	output ctrl_cmd_t  cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOK,
		ST_READ
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   can_load;

	assign can_load = !out_valid_q || out_ready;

	always_comb begin
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: in_ready = 1'b1;
			ST_READ: in_ready = can_load;
			default: in_ready = 1'b0;
		endcase
	end

	assign cmd.load_req = in_valid && in_ready;
	assign cmd.lookup   = (state_q == ST_LOOK);
	assign cmd.load_out = (state_q == ST_READ) && can_load;
	assign out_valid    = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (cmd.load_req) begin
						state_q <= ST_LOOK;
					end
				end
				ST_LOOK: begin
					state_q <= ST_READ;
				end
				ST_READ: begin
					// A new request may enter in the same cycle the result moves out.
					if (can_load) begin
						state_q <= cmd.load_req ? ST_LOOK : ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_look_then_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOOK) |=> (state_q == ST_READ))
		else $error("lookup cycle not followed by result cycle");

	a_load_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |=> out_valid_q)
		else $error("result loaded but not presented");

	a_no_accept_in_lookup: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOOK) |-> !in_ready)
		else $error("request accepted during lookup");

endmodule

// ----- sv/tlb_dp.sv -----
`timescale 1ns / 1ps

module tlb_dp
	import tlb_pkg::*;
#(
	parameter int TLB_ENTRIES = TLB_ENTRIES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  ctrl_cmd_t           cmd,
	input  req_t                in_data,
	input  logic                cfg_we,
	input  logic [ACTIVE_W-1:0] cfg_data,
	output rsp_t                out_data
);

	localparam int IDX_W = $clog2(TLB_ENTRIES);

	req_t                 req_q;
	rsp_t                 out_q;
	logic [ACTIVE_W-1:0]  active_q;
	logic [COUNT_W-1:0]   hit_cnt_q;
	logic [TLB_ENTRIES-1:0] valid_q, used_q, dirty_q;
	logic [PAGE_BITS-1:0] page_q [TLB_ENTRIES];

	logic [TLB_ENTRIES-1:0] act, match, inval, unused, clear_vec;
	logic                   any_hit, any_inv, any_clr;
	logic [IDX_W-1:0]       hit_idx, inv_idx, clr_idx, victim, sel_idx;
	logic                   hit_s2;
	logic [IDX_W-1:0]       idx_s2;
	logic [PAGE_BITS-1:0]   ram_rdata;
	logic [IDX_W+INDEX_OUT_W-1:0] idx_ext;

	// Entry zero is always in use; counts above the entry count saturate on their own.
	for (genvar i = 0; i < TLB_ENTRIES; i++) begin : g_entry
		localparam logic [31:0] IV = 32'(i);
		assign act[i]    = (i == 0) || (IV < 32'(active_q));
		assign match[i]  = act[i] && valid_q[i] && (page_q[i] == req_q.virtual_page);
		assign inval[i]  = act[i] && !valid_q[i];
		assign unused[i] = act[i] && !used_q[i];
		// The clock hand clears every used bit it passes before the victim.
		assign clear_vec[i] = cmd.lookup && !any_hit && !any_inv && act[i] &&
			(!any_clr || (IDX_W'(i) < clr_idx)) && (IDX_W'(i) != victim);
	end

	always_comb begin
		hit_idx = '0;
		inv_idx = '0;
		clr_idx = '0;
		for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
			if (match[i]) begin
				hit_idx = IDX_W'(i);
			end
			if (inval[i]) begin
				inv_idx = IDX_W'(i);
			end
			if (unused[i]) begin
				clr_idx = IDX_W'(i);
			end
		end
	end

	assign any_hit = |match;
	assign any_inv = |inval;
	assign any_clr = |unused;
	assign victim  = any_inv ? inv_idx : (any_clr ? clr_idx : '0);
	assign sel_idx = any_hit ? hit_idx : victim;

	tlb_ram #(
		.WIDTH(PAGE_BITS),
		.DEPTH(TLB_ENTRIES)
	) u_frame_ram (
		.clk  (clk),
		.we   (cmd.lookup && !any_hit),
		.waddr(sel_idx),
		.wdata(req_q.walk_frame),
		.re   (cmd.lookup && any_hit),
		.raddr(hit_idx),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q  <= ACTIVE_RESET;
			hit_cnt_q <= '0;
			valid_q   <= '0;
			used_q    <= '0;
			dirty_q   <= '0;
		end else begin
			if (cfg_we) begin
				active_q <= cfg_data;
			end
			if (cmd.lookup) begin
				if (any_hit) begin
					used_q[hit_idx]  <= 1'b1;
					dirty_q[hit_idx] <= dirty_q[hit_idx] | req_q.is_write;
					hit_cnt_q        <= hit_cnt_q + COUNT_W'(1);
				end else begin
					for (int i = 0; i < TLB_ENTRIES; i++) begin
						if (clear_vec[i]) begin
							used_q[i] <= 1'b0;
						end
					end
					valid_q[victim] <= 1'b1;
					used_q[victim]  <= 1'b1;
					dirty_q[victim] <= req_q.is_write;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			req_q <= in_data;
		end
		if (cmd.lookup) begin
			hit_s2 <= any_hit;
			idx_s2 <= sel_idx;
			if (!any_hit) begin
				page_q[victim] <= req_q.virtual_page;
			end
		end
		if (cmd.load_out) begin
			out_q.frame        <= hit_s2 ? ram_rdata : req_q.walk_frame;
			out_q.hit          <= hit_s2;
			out_q.filled_index <= idx_ext[INDEX_OUT_W-1:0];
			out_q.hit_total    <= hit_cnt_q;
		end
	end

	assign idx_ext  = {{INDEX_OUT_W{1'b0}}, idx_s2};
	assign out_data = out_q;

endmodule

// ----- sv/tlb_lookup_clock_replace.sv -----
`timescale 1ns / 1ps

// Channel  | Handshake            | Beat
// ---------+----------------------+------------------------------------------
// in       | in_valid / in_ready  | in_data: virtual_page, is_write, walk_frame
// out      | out_valid / out_ready| out_data: frame, hit, filled_index, hit_total
// cfg      | cfg_we               | cfg_data: active_entries
//
// A request passes a lookup state, for the parallel tag compare, victim pick, state
// update and frame RAM read, then a result state that loads the output register.
// A new beat is taken in the cycle the previous result enters the output register.
// Reset clears valid, used and dirty bits, the hit counter, and sets 16 active entries.
// A stalled output holds the block in its result cycle until out_ready frees the register.
module tlb_lookup_clock_replace
	import tlb_pkg::*;
#(
	parameter int TLB_ENTRIES = TLB_ENTRIES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  req_t                in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output rsp_t                out_data,
	input  logic                cfg_we,
	input  logic [ACTIVE_W-1:0] cfg_data
);

	ctrl_cmd_t cmd;

	tlb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.cmd      (cmd)
	);

	tlb_dp #(
		.TLB_ENTRIES(TLB_ENTRIES)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.in_data (in_data),
		.cfg_we  (cfg_we),
		.cfg_data(cfg_data),
		.out_data(out_data)
	);

endmodule
